[hw/rtl/mcn_pkg.sv]
// ----------------------------------------------------------------------------
// mcn_pkg
// Types and constants shared by the Morton cell neighbor block.
// ----------------------------------------------------------------------------
package mcn_pkg;

  localparam int LEVEL_W = 6;
  localparam int CODE_W  = 64;
  localparam int MODE_W  = 2;
  localparam int SHAMT_W = 7;

  // Highest level used for movement; larger levels saturate here
  localparam logic [LEVEL_W-1:0] MAX_CODE_LEVEL = LEVEL_W'(32);

  localparam logic [CODE_W-1:0] ODD_BITS  = 64'haaaa_aaaa_aaaa_aaaa;
  localparam logic [CODE_W-1:0] EVEN_BITS = 64'h5555_5555_5555_5555;
  localparam logic [CODE_W-1:0] ALL_ONES  = {CODE_W{1'b1}};

  // Axis mode register codes
  localparam logic [MODE_W-1:0] MODE_LAT_EVEN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LAT_ODD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_LAT_EVEN;

  typedef struct packed {
    logic [LEVEL_W-1:0] cell_level;
    logic [CODE_W-1:0]  code_in;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_echo;
    logic [CODE_W-1:0]  center_code;
    logic [CODE_W-1:0]  north_code;
    logic [CODE_W-1:0]  east_code;
    logic [CODE_W-1:0]  west_code;
    logic [CODE_W-1:0]  south_code;
    logic [CODE_W-1:0]  southeast_code;
    logic [CODE_W-1:0]  northwest_code;
    logic [CODE_W-1:0]  southwest_code;
    logic [CODE_W-1:0]  northeast_code;
  } rsp_t;

endpackage

[hw/rtl/mcn_stream_if.sv]
// ----------------------------------------------------------------------------
// mcn_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface mcn_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mcn_neighbor_calc.sv]
// ----------------------------------------------------------------------------
// mcn_neighbor_calc
// Masked increment/decrement of each interleaved axis and selection of the
// eight neighbor codes by axis mode.
// ----------------------------------------------------------------------------
module mcn_neighbor_calc
  import mcn_pkg::*;
(
  input  req_t              req,
  input  logic [MODE_W-1:0] axis_mode,
  output rsp_t              rsp
);

  logic [LEVEL_W-1:0] lvl_sat;
  logic [SHAMT_W-1:0] shamt;
  logic [CODE_W-1:0]  low_mask;
  logic [CODE_W-1:0]  odd_a, even_a;
  logic [CODE_W-1:0]  odd_fill, even_fill;
  logic [CODE_W-1:0]  odd_inc, odd_dec, even_inc, even_dec;
  logic [CODE_W-1:0]  code;

  assign code = req.code_in;

  // Saturate level and build the mask of the low 2*level bits
  assign lvl_sat  = (req.cell_level > MAX_CODE_LEVEL) ? MAX_CODE_LEVEL : req.cell_level;
  assign shamt    = {lvl_sat, 1'b0};
  assign low_mask = ~(ALL_ONES << shamt);

  // Split axes; fill the other axis's bits so carries ripple across gaps
  assign odd_a     = code & ODD_BITS;
  assign even_a    = code & EVEN_BITS;
  assign odd_fill  = EVEN_BITS & low_mask;
  assign even_fill = ODD_BITS & low_mask;

  assign odd_inc  = (odd_a + odd_fill + 64'd1) & ODD_BITS & low_mask;
  assign odd_dec  = ((odd_a | odd_fill) - (odd_fill + 64'd1)) & ODD_BITS & low_mask;
  assign even_inc = (even_a + even_fill + 64'd1) & EVEN_BITS & low_mask;
  assign even_dec = ((even_a | even_fill) - (even_fill + 64'd1)) & EVEN_BITS & low_mask;

  // Select neighbors by which axis carries latitude
  always_comb begin
    rsp.level_echo     = req.cell_level;
    rsp.center_code    = code;
    rsp.southwest_code = odd_dec | even_dec;
    rsp.northeast_code = odd_inc | even_inc;
    unique case (axis_mode)
      MODE_LAT_EVEN: begin
        rsp.north_code     = odd_a | even_inc;
        rsp.east_code      = odd_inc | even_a;
        rsp.west_code      = odd_dec | even_a;
        rsp.south_code     = odd_a | even_dec;
        rsp.southeast_code = odd_inc | even_dec;
        rsp.northwest_code = odd_dec | even_inc;
      end
      MODE_LAT_ODD: begin
        rsp.north_code     = odd_inc | even_a;
        rsp.east_code      = odd_a | even_inc;
        rsp.west_code      = odd_a | even_dec;
        rsp.south_code     = odd_dec | even_a;
        rsp.southeast_code = odd_dec | even_inc;
        rsp.northwest_code = odd_inc | even_dec;
      end
      default: begin
        rsp.north_code     = code;
        rsp.east_code      = code;
        rsp.west_code      = code;
        rsp.south_code     = code;
        rsp.southeast_code = code;
        rsp.northwest_code = code;
      end
    endcase
  end

endmodule

[hw/rtl/morton_cell_neighbors.sv]
// ----------------------------------------------------------------------------
// morton_cell_neighbors
// Returns a Morton cell code with the codes of its eight neighbors.
// ----------------------------------------------------------------------------
// Stages: input register, neighbor logic, result register.
// Throughput: one request per cycle while the output is not stalled; set
//   by the single pass through the four masked 64-bit add/subtract units.
// Reset: rst (synchronous) empties both stages and sets axis_mode to 0.
module morton_cell_neighbors
  import mcn_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  mcn_stream_if.sink   code_req,
  mcn_stream_if.source nbr_rsp,
  mcn_stream_if.sink   cfg
);

  logic [MODE_W-1:0] axis_mode;
  logic              req_valid;
  req_t              req_q;
  logic              rsp_valid;
  rsp_t              rsp_q;
  rsp_t              rsp_next;
  logic              rsp_load;

  // Configuration write, always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_mode <= MODE_RESET;
    end else if (cfg.valid) begin
      axis_mode <= cfg.data;
    end
  end

  // Stage control: each stage advances when the next one frees up
  assign rsp_load       = !rsp_valid || nbr_rsp.ready;
  assign code_req.ready = !req_valid || rsp_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (code_req.ready) begin
      req_valid <= code_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (code_req.valid && code_req.ready) begin
      req_q <= code_req.data;
    end
  end

  mcn_neighbor_calc u_calc (
    .req       (req_q),
    .axis_mode (axis_mode),
    .rsp       (rsp_next)
  );

  // Result register; hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load && req_valid) begin
      rsp_q <= rsp_next;
    end
  end

  assign nbr_rsp.valid = rsp_valid;
  assign nbr_rsp.data  = rsp_q;

endmodule

[hw/rtl/mcn_checker.sv]
// ----------------------------------------------------------------------------
// mcn_checker
// Port-level checks for morton_cell_neighbors, bound to the top level.
// ----------------------------------------------------------------------------
module mcn_checker
  import mcn_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input rsp_t              rsp_data,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [MODE_W-1:0] cfg_data
);

  logic [MODE_W-1:0] mode_seen;

  // Track the mode as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_seen <= MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode_seen <= cfg_data;
    end
  end

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

  // Requests are refused only while a result waits at the output
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("request refused with empty output");

  // Unsupported mode returns edge neighbors and the southeast and northwest diagonals unmoved
  a_unsupported_mode: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (mode_seen != MODE_LAT_EVEN) && (mode_seen != MODE_LAT_ODD) |->
      rsp_data.north_code == rsp_data.center_code &&
      rsp_data.east_code == rsp_data.center_code &&
      rsp_data.west_code == rsp_data.center_code &&
      rsp_data.south_code == rsp_data.center_code &&
      rsp_data.southeast_code == rsp_data.center_code &&
      rsp_data.northwest_code == rsp_data.center_code)
    else $error("unsupported mode moved an edge neighbor");

  // Level zero clears both moved axes of the northeast and southwest diagonals
  a_level_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.level_echo == '0 |->
      rsp_data.northeast_code == '0 && rsp_data.southwest_code == '0)
    else $error("level zero diagonal not zero");

endmodule

bind morton_cell_neighbors mcn_checker u_mcn_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (code_req.valid),
  .req_ready (code_req.ready),
  .rsp_valid (nbr_rsp.valid),
  .rsp_ready (nbr_rsp.ready),
  .rsp_data  (nbr_rsp.data),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready),
  .cfg_data  (cfg.data)
);

[tb/mcn_nbr_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcn_nbr_checker
// Watches the request, result and mode channels of the Morton neighbor
// block, predicts the nine codes of every accepted request and compares
// each accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module mcn_nbr_checker
  import mcn_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  mcn_stream_if code_mon,
  mcn_stream_if nbr_mon,
  mcn_stream_if cfg_mon,
  output int    pending,
  output int    fail_count,
  output int    results_seen
);

  localparam int REPORT_LIMIT = 10;

  logic [MODE_W-1:0] mode_q;
  rsp_t              pending_nbrs[$];

  // Pattern restricted to its low 2*lvl bits
  function automatic logic [CODE_W-1:0] level_mask(input logic [CODE_W-1:0] pattern,
                                                    input int unsigned lvl);
    if (lvl == 0) return '0;
    return pattern >> (CODE_W - 2 * lvl);
  endfunction

  // Step one axis by dir (-1, 0, +1); carries ripple through the other axis
  function automatic logic [CODE_W-1:0] step_axis(input logic [CODE_W-1:0] code,
                                                   input int unsigned lvl,
                                                   input int dir,
                                                   input logic [CODE_W-1:0] axis_bits,
                                                   input logic [CODE_W-1:0] other_bits);
    logic [CODE_W-1:0] moved;
    logic [CODE_W-1:0] kept;
    logic [CODE_W-1:0] fill;
    if (dir == 0) return code;
    moved = code & axis_bits;
    kept  = code & other_bits;
    fill  = level_mask(other_bits, lvl);
    if (dir > 0) begin
      moved = moved + (fill + 64'd1);
    end else begin
      moved = (moved | fill) - (fill + 64'd1);
    end
    moved &= level_mask(axis_bits, lvl);
    return moved | kept;
  endfunction

  function automatic logic [CODE_W-1:0] shift_code(input logic [CODE_W-1:0] code,
                                                    input int unsigned lvl,
                                                    input int odd_dir,
                                                    input int even_dir);
    logic [CODE_W-1:0] c;
    c = step_axis(code, lvl, odd_dir, ODD_BITS, EVEN_BITS);
    return step_axis(c, lvl, even_dir, EVEN_BITS, ODD_BITS);
  endfunction

  function automatic rsp_t predict_nbrs(input req_t r, input logic [MODE_W-1:0] mode);
    rsp_t              p;
    int unsigned       lvl;
    int                lat_odd;
    int                lat_even;
    int                lon_odd;
    int                lon_even;
    logic [CODE_W-1:0] c;
    c   = r.code_in;
    lvl = (r.cell_level > MAX_CODE_LEVEL) ? int'(MAX_CODE_LEVEL) : int'(r.cell_level);
    lat_odd  = (mode == MODE_LAT_ODD)  ? 1 : 0;
    lat_even = (mode == MODE_LAT_EVEN) ? 1 : 0;
    lon_odd  = lat_even;
    lon_even = lat_odd;
    p.level_echo  = r.cell_level;
    p.center_code = c;
    if (mode == MODE_LAT_EVEN || mode == MODE_LAT_ODD) begin
      p.north_code     = shift_code(c, lvl, lat_odd, lat_even);
      p.east_code      = shift_code(c, lvl, lon_odd, lon_even);
      p.west_code      = shift_code(c, lvl, -lon_odd, -lon_even);
      p.south_code     = shift_code(c, lvl, -lat_odd, -lat_even);
      p.southeast_code = shift_code(c, lvl, lon_odd - lat_odd, lon_even - lat_even);
      p.northwest_code = shift_code(c, lvl, lat_odd - lon_odd, lat_even - lon_even);
    end else begin
      // Unsupported mode: edge and opposite-direction diagonals come back unmoved
      p.north_code     = c;
      p.east_code      = c;
      p.west_code      = c;
      p.south_code     = c;
      p.southeast_code = c;
      p.northwest_code = c;
    end
    p.southwest_code = shift_code(c, lvl, -1, -1);
    p.northeast_code = shift_code(c, lvl, 1, 1);
    return p;
  endfunction

  task automatic note_failure(input string what, input logic [CODE_W-1:0] exp_v,
                              input logic [CODE_W-1:0] got_v);
    if (fail_count < REPORT_LIMIT)
      $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [CODE_W-1:0] exp_v,
                             input logic [CODE_W-1:0] got_v);
    if (got_v !== exp_v) note_failure(what, exp_v, got_v);
  endtask

  // Track mode, queue predictions on request accept, compare on result accept
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      pending_nbrs.delete();
      mode_q       = MODE_RESET;
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (nbr_mon.valid && nbr_mon.ready) begin
        got = nbr_mon.data;
        results_seen++;
        if (pending_nbrs.size() == 0) begin
          note_failure("unexpected result, center", '0, got.center_code);
        end else begin
          want = pending_nbrs.pop_front();
          check_field("level_echo", {58'd0, want.level_echo}, {58'd0, got.level_echo});
          check_field("center_code", want.center_code, got.center_code);
          check_field("north_code", want.north_code, got.north_code);
          check_field("east_code", want.east_code, got.east_code);
          check_field("west_code", want.west_code, got.west_code);
          check_field("south_code", want.south_code, got.south_code);
          check_field("southeast_code", want.southeast_code, got.southeast_code);
          check_field("northwest_code", want.northwest_code, got.northwest_code);
          check_field("southwest_code", want.southwest_code, got.southwest_code);
          check_field("northeast_code", want.northeast_code, got.northeast_code);
        end
      end
      if (code_mon.valid && code_mon.ready)
        pending_nbrs.push_back(predict_nbrs(code_mon.data, mode_q));
      if (cfg_mon.valid && cfg_mon.ready)
        mode_q = cfg_mon.data;
    end
    pending = pending_nbrs.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Morton cell neighbor block: directed corner
// cases, then random phases under every axis mode with random idling on
// both channels, a long result hold-off and a full drain mid-run.
// ----------------------------------------------------------------------------
module tb;
  import mcn_pkg::*;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_UNSUP_LO = 2'd2;
  localparam mode_t MODE_UNSUP_HI = 2'd3;
  localparam int    NUM_PHASES    = 8;
  localparam int    PHASE_ITEMS   = 190;
  localparam int    LONG_STALL    = 80;
  localparam int    CYCLE_LIMIT   = 200000;

  logic clk;
  logic rst;

  mcn_stream_if #(.payload_t(req_t))  code_req_if ();
  mcn_stream_if #(.payload_t(rsp_t))  nbr_rsp_if ();
  mcn_stream_if #(.payload_t(mode_t)) cfg_if ();

  int pending;
  int fail_count;
  int results_seen;
  int items_sent;
  int cycle_count;
  int stall_ask;
  int stall_seen;
  int rsp_hold;
  int rsp_burst;
  bit quiet;
  bit [3:0] modes_used;

  morton_cell_neighbors uut (
    .clk      (clk),
    .rst      (rst),
    .code_req (code_req_if),
    .nbr_rsp  (nbr_rsp_if),
    .cfg      (cfg_if)
  );

  mcn_nbr_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .code_mon     (code_req_if),
    .nbr_mon      (nbr_rsp_if),
    .cfg_mon      (cfg_if),
    .pending      (pending),
    .fail_count   (fail_count),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Count cycles for the timeout
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
    $display("end of test: mismatches");
    $finish;
  end

  // Result-side ready: random bursts of back-pressure, one long hold-off on request
  initial begin
    nbr_rsp_if.ready = 1'b0;
    stall_seen = 0;
    rsp_hold   = 0;
    rsp_burst  = 0;
    forever begin
      @(negedge clk);
      if (stall_seen != stall_ask) begin
        stall_seen = stall_ask;
        rsp_hold   = LONG_STALL;
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        nbr_rsp_if.ready <= 1'b0;
      end else if (quiet) begin
        nbr_rsp_if.ready <= 1'b1;
      end else if (rsp_burst > 0) begin
        rsp_burst--;
        nbr_rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        rsp_burst = $urandom_range(1, 5) - 1;
        nbr_rsp_if.ready <= 1'b0;
      end else begin
        nbr_rsp_if.ready <= 1'b1;
      end
    end
  end

  // Offer one request at a falling edge; return at the falling edge after accept
  task automatic send_req(input logic [LEVEL_W-1:0] lvl, input logic [CODE_W-1:0] code);
    code_req_if.valid <= 1'b1;
    code_req_if.data  <= '{cell_level: lvl, code_in: code};
    do @(posedge clk); while (!code_req_if.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic hold_req(input int cycles);
    code_req_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Drain, let the pipeline settle, then write the mode register
  task automatic write_mode(input mode_t m);
    code_req_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= m;
    do @(posedge clk); while (!cfg_if.ready);
    modes_used[m] = 1'b1;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Random request, often pushed to a carry or borrow across the whole axis
  task automatic send_random();
    logic [LEVEL_W-1:0] lvl;
    logic [CODE_W-1:0]  code;
    logic [CODE_W-1:0]  axis_bits;
    logic [CODE_W-1:0]  wrap_bits;
    int unsigned        used;
    lvl  = ($urandom_range(0, 6) == 0) ? LEVEL_W'($urandom_range(33, 63))
                                       : LEVEL_W'($urandom_range(0, 32));
    code = {$urandom(), $urandom()};
    used = (lvl > MAX_CODE_LEVEL) ? 32 : int'(lvl);
    axis_bits = $urandom_range(0, 1) ? ODD_BITS : EVEN_BITS;
    wrap_bits = (used == 0) ? '0 : axis_bits >> (CODE_W - 2 * used);
    case ($urandom_range(0, 7))
      0: code = code | wrap_bits;
      1: code = code & ~wrap_bits;
      2: code = code | (ODD_BITS >> (CODE_W - 2 * (used == 0 ? 1 : used)));
      default: ;
    endcase
    send_req(lvl, code);
  endtask

  initial begin
    mode_t phase_mode;
    int    drain_at;
    rst               = 1'b1;
    code_req_if.valid = 1'b0;
    code_req_if.data  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    items_sent        = 0;
    stall_ask         = 0;
    quiet             = 1'b0;
    modes_used        = 4'b0001;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset mode, level extremes, saturation, wrap patterns
    send_req(6'd0, '1);
    send_req(6'd0, '0);
    send_req(6'd32, '1);
    send_req(6'd32, '0);
    send_req(6'd1, 64'h3);
    send_req(6'd31, ODD_BITS);
    send_req(6'd33, EVEN_BITS);
    send_req(6'd63, 64'h0123_4567_89ab_cdef);

    // Directed: latitude on odd bits
    write_mode(MODE_LAT_ODD);
    send_req(6'd0, 64'hfedc_ba98_7654_3210);
    send_req(6'd32, '1);
    send_req(6'd16, 64'hffff_0000_0000_ffff);
    send_req(6'd1, '0);
    send_req(6'd40, ODD_BITS);

    // Directed: unsupported modes leave edges unmoved
    write_mode(MODE_UNSUP_LO);
    send_req(6'd32, '1);
    send_req(6'd0, 64'hdead_beef_cafe_f00d);
    send_req(6'd20, '0);
    write_mode(MODE_UNSUP_HI);
    send_req(6'd5, 64'h3ff);
    send_req(6'd63, '1);
    send_req(6'd32, EVEN_BITS);
    write_mode(MODE_LAT_EVEN);
    send_req(6'd8, 64'hffff);
    send_req(6'd12, 64'h1_0000_0000);

    // Random phases under each mode, then random modes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      phase_mode = (ph < 4) ? mode_t'(ph) : mode_t'($urandom_range(0, 3));
      write_mode(phase_mode);
      if (ph == NUM_PHASES - 1) quiet <= 1'b1;
      drain_at = (ph == 5) ? PHASE_ITEMS / 2 : -1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold off results and keep offering so the pipeline backs up
        if (ph == 2 && i == 10) stall_ask <= stall_ask + 1;
        if (i == drain_at) begin
          code_req_if.valid <= 1'b0;
          wait (pending == 0);
          @(negedge clk);
        end
        if (!quiet && !(ph == 2 && i >= 10 && i < 50) && $urandom_range(0, 7) == 0)
          hold_req($urandom_range(1, 5));
        send_random();
      end
    end

    // Drain and let the last results settle
    code_req_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);

    $display("sent %0d requests, compared %0d results; modes written mask %b",
             items_sent, results_seen, modes_used);
    $display("levels 0..63 incl. saturation, forced axis wraps, long stall and drain done");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, pending);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mcn_pkg.sv
hw/rtl/mcn_stream_if.sv
hw/rtl/mcn_neighbor_calc.sv
hw/rtl/morton_cell_neighbors.sv
hw/rtl/mcn_checker.sv
tb/mcn_nbr_checker.sv
tb/tb.sv
